FILE: rtl/softmax_entropy_vesselness_assert.svh
// assertion macros for the softmax entropy vesselness block
// expects clk and rst_n in the scope of use
`ifndef SOFTMAX_ENTROPY_VESSELNESS_ASSERT_SVH
`define SOFTMAX_ENTROPY_VESSELNESS_ASSERT_SVH
`ifndef SYNTHESIS
`define SEV_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sev assertion failed");
`define SEV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sev assertion failed");
`define SEV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sev assertion failed");
`else
`define SEV_ASSERT(lbl, cond)
`define SEV_ASSERT_IMP(lbl, ante, cons)
`define SEV_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/sev_pkg.sv
// shared types and constants of the softmax entropy vesselness block
// no dependencies
`default_nettype none
package sev_pkg;

  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;

  localparam logic signed [21:0] ARG_MIN = -22'sd1572864;
  localparam logic signed [21:0] ARG_MAX = 22'sd1048575;

  localparam logic [1:0] REG_BETA = 2'd0;
  localparam logic [1:0] REG_TAU  = 2'd1;
  localparam logic [1:0] REG_ODF  = 2'd2;

  typedef logic signed [21:0] exp_arg_t;

  typedef struct packed {
    logic start;
    logic q24;
  } exp_ctl_t;

  // floor(2^33 / n) for the taylor term divide
  function automatic logic [33:0] recip(input logic [3:0] n);
    logic [33:0] r;
    unique case (n)
      4'd1:    r = 34'd8589934592;
      4'd2:    r = 34'd4294967296;
      4'd3:    r = 34'd2863311530;
      4'd4:    r = 34'd2147483648;
      4'd5:    r = 34'd1717986918;
      4'd6:    r = 34'd1431655765;
      4'd7:    r = 34'd1227133513;
      4'd8:    r = 34'd1073741824;
      4'd9:    r = 34'd954437176;
      4'd10:   r = 34'd858993459;
      4'd11:   r = 34'd780903144;
      4'd12:   r = 34'd715827882;
      default: r = 34'd8589934592;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sev_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module sev_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/sev_exp.sv
// fixed point exp unit: 2^i split, 12 term taylor series, final rounding shift
// depends on sev_pkg
`default_nettype none
module sev_exp
  import sev_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  exp_ctl_t    ctl,
  input  exp_arg_t    x,
  output logic        done,
  output logic [47:0] res
);

  typedef enum logic [2:0] {E_IDLE, E_LOG2, E_FRAC, E_TMUL, E_TDIV, E_TFIX, E_SHIFT} est_t;

  est_t               state_r;
  exp_arg_t           x_r;
  logic               q24_r;
  logic signed [53:0] y_r;
  logic [31:0]        g_r;
  logic [32:0]        term_r;
  logic [32:0]        prod_r;
  logic [32:0]        q0_r;
  logic [33:0]        m_r;
  logic [3:0]         n_r;
  logic               done_r;
  logic [47:0]        res_r;

  logic [63:0]        fprod_c;
  logic [64:0]        tprod_c;
  logic [66:0]        dprod_c;
  logic [36:0]        qn_c;
  logic [32:0]        rr_c;
  logic [32:0]        tq_c;
  logic signed [8:0]  s_c;
  logic [8:0]         sh_c;
  logic [63:0]        rnd_c;
  logic [47:0]        shres_c;

  always_comb begin
    fprod_c = y_r[45:14] * LN2_Q32;
    tprod_c = term_r * g_r;
    dprod_c = prod_r * recip(n_r);
    qn_c    = q0_r * n_r;
    rr_c    = prod_r - qn_c[32:0];
    tq_c    = (rr_c >= {29'd0, n_r}) ? q0_r + 33'd1 : q0_r;
    s_c     = {y_r[53], y_r[53:46]} - (q24_r ? 9'sd8 : 9'sd16);
    sh_c    = 9'(-s_c);
    rnd_c   = {30'd0, m_r} + (64'd1 << (sh_c[5:0] - 6'd1));
    if (!s_c[8]) begin
      shres_c = 48'({30'd0, m_r} << s_c[5:0]);
    end else if (sh_c > 9'd62) begin
      shres_c = '0;
    end else begin
      shres_c = 48'(rnd_c >> sh_c[5:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        E_IDLE: begin
          if (ctl.start) begin
            x_r     <= x;
            q24_r   <= ctl.q24;
            state_r <= E_LOG2;
          end
        end
        E_LOG2: begin
          y_r     <= x_r * $signed({1'b0, LOG2E_Q30});
          state_r <= E_FRAC;
        end
        E_FRAC: begin
          g_r     <= fprod_c[63:32];
          term_r  <= 33'h1_0000_0000;
          m_r     <= 34'h1_0000_0000;
          n_r     <= 4'd1;
          state_r <= E_TMUL;
        end
        E_TMUL: begin
          prod_r  <= tprod_c[64:32];
          state_r <= E_TDIV;
        end
        E_TDIV: begin
          q0_r    <= dprod_c[65:33];
          state_r <= E_TFIX;
        end
        E_TFIX: begin
          term_r <= tq_c;
          m_r    <= m_r + {1'b0, tq_c};
          if (n_r == 4'd12) begin
            state_r <= E_SHIFT;
          end else begin
            n_r     <= n_r + 4'd1;
            state_r <= E_TMUL;
          end
        end
        E_SHIFT: begin
          res_r   <= shres_c;
          done_r  <= 1'b1;
          state_r <= E_IDLE;
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

FILE: rtl/softmax_entropy_vesselness.sv
// top level of the softmax entropy vesselness block
// depends on sev_pkg, sev_exp, sev_ram and the assertion macro header
//
// One request per direction sample, one sample in flight at a time. A stored
// sample waits for the 12 term taylor loop of the shared exp unit (a multiply,
// divide and fix state per term). A last sample then starts a pass over the
// weight memory with, per stored component, a memory read, a divide, a
// squaring log and an accumulate, plus waiting for the result side when
// probabilities are sent, then the final exp. A sample beyond MAX_COMPONENTS
// is not stored and only marks the voxel as dropped.
`default_nettype none
`include "softmax_entropy_vesselness_assert.svh"
module softmax_entropy_vesselness
  import sev_pkg::*;
#(
  parameter int MAX_COMPONENTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [16:0]        out_value,
  output logic               out_dropped,
  output logic               out_end_of_voxel,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_COMPONENTS + 1);
  localparam int AW    = $clog2(MAX_COMPONENTS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COMPONENTS);
  localparam logic signed [41:0] XMIN = -42'sd1572864;
  localparam logic signed [41:0] XMAX = 42'sd1048575;

  typedef enum logic [3:0] {
    S_IDLE, S_WEXP, S_PINIT, S_PASS, S_RD, S_RDW, S_DIV, S_LOGINIT, S_LOG,
    S_LNMUL, S_ACC, S_EMIT, S_RES_MUL, S_RES_EXP, S_RES_WAIT, S_RES_EMIT
  } st_t;

  st_t              state_r;
  logic [23:0]      beta_r;
  logic [23:0]      tau_r;
  logic             odf_r;
  logic [53:0]      sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  logic             last_r;
  logic [CNT_W-1:0] idx_r;
  logic             norm_r;
  logic             drop_r;
  logic             odfl_r;
  logic [69:0]      rem_r;
  logic [69:0]      div_r;
  logic [16:0]      q_r;
  logic [4:0]       step_r;
  logic [31:0]      z_r;
  logic [23:0]      frac_r;
  logic [4:0]       k_r;
  logic [28:0]      ln_r;
  logic [45:0]      acc_r;
  logic [30:0]      ex_r;
  logic [16:0]      vres_r;
  logic             out_valid_r;
  logic             out_kind_r;
  logic [16:0]      out_value_r;
  logic             out_dropped_r;
  logic             out_eov_r;

  exp_ctl_t         exp_ctl;
  exp_arg_t         exp_x;
  logic             exp_done;
  logic [47:0]      exp_res;
  logic [47:0]      rd_data;

  logic               in_acc_c;
  logic               out_free_c;
  logic               out_load_c;
  logic signed [40:0] bprod_c;
  logic signed [41:0] negx_c;
  exp_arg_t           wx_c;
  exp_arg_t           vx_c;
  logic [16:0]        p_c;
  logic [4:0]         kp_c;
  logic               ge_c;
  logic [63:0]        zz_c;
  logic [31:0]        zs_c;
  logic [28:0]        nl_c;
  logic [60:0]        lnp_c;
  logic [45:0]        ner_c;
  logic [54:0]        exm_c;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc_c   = in_valid && in_ready;
  assign out_free_c = !out_valid_r || out_ready;
  assign out_load_c = out_free_c &&
                      (((state_r == S_EMIT) && odfl_r) || (state_r == S_RES_EMIT));

  always_comb begin
    bprod_c = $signed({1'b0, beta_r}) * in_sample;
    negx_c  = -$signed({bprod_c[40], bprod_c});
    if (negx_c < XMIN) begin
      wx_c = ARG_MIN;
    end else if (negx_c > XMAX) begin
      wx_c = ARG_MAX;
    end else begin
      wx_c = negx_c[21:0];
    end
    vx_c = (ex_r > 31'd1572864) ? ARG_MIN : -$signed({1'b0, ex_r[20:0]});
    p_c  = (q_r > 17'd65536) ? 17'd65536 : q_r;
    kp_c = '0;
    for (int i = 0; i < 17; i++) begin
      if (p_c[i]) begin
        kp_c = 5'(i);
      end
    end
    ge_c  = (rem_r >= div_r);
    zz_c  = z_r * z_r;
    zs_c  = zz_c[61:30];
    nl_c  = {5'(5'd16 - k_r), 24'd0} - {5'd0, frac_r};
    lnp_c = nl_c * LN2_Q32;
    ner_c = acc_r + 46'd32768;
    exm_c = (tau_r * ner_c[45:16]) + 55'd8388608;
  end

  always_comb begin
    exp_ctl.start = (in_acc_c && (cnt_r < CNT_MAX)) || (state_r == S_RES_EXP);
    exp_ctl.q24   = (state_r == S_IDLE);
    exp_x         = (state_r == S_IDLE) ? wx_c : vx_c;
  end

  sev_exp u_exp (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (exp_ctl),
    .x    (exp_x),
    .done (exp_done),
    .res  (exp_res)
  );

  sev_ram #(
    .WIDTH(48),
    .DEPTH(MAX_COMPONENTS)
  ) u_wram (
    .clk  (clk),
    .we   ((state_r == S_WEXP) && exp_done),
    .waddr(cnt_r[AW-1:0]),
    .wdata(exp_res),
    .raddr(idx_r[AW-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      beta_r      <= 24'd655;
      tau_r       <= 24'd65536;
      odf_r       <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BETA: beta_r <= cfg_wdata;
          REG_TAU:  tau_r  <= cfg_wdata;
          REG_ODF:  odf_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_load_c) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc_c) begin
            last_r <= in_last;
            if (cnt_r < CNT_MAX) begin
              state_r <= S_WEXP;
            end else begin
              ovf_r <= 1'b1;
              if (in_last) begin
                state_r <= S_PINIT;
              end
            end
          end
        end
        S_WEXP: begin
          if (exp_done) begin
            sum_r   <= sum_r + {6'd0, exp_res};
            cnt_r   <= cnt_r + 1'b1;
            state_r <= last_r ? S_PINIT : S_IDLE;
          end
        end
        S_PINIT: begin
          norm_r  <= (sum_r > 54'd16);
          drop_r  <= ovf_r;
          odfl_r  <= odf_r;
          idx_r   <= '0;
          acc_r   <= '0;
          state_r <= S_PASS;
        end
        S_PASS: begin
          state_r <= (idx_r == cnt_r) ? S_RES_MUL : S_RD;
        end
        S_RD: begin
          state_r <= S_RDW;
        end
        S_RDW: begin
          rem_r  <= {6'd0, rd_data, 16'd0} + {17'd0, sum_r[53:1]};
          div_r  <= {sum_r, 16'd0};
          q_r    <= '0;
          step_r <= 5'd16;
          state_r <= norm_r ? S_DIV : S_EMIT;
        end
        S_DIV: begin
          if (ge_c) begin
            rem_r <= rem_r - div_r;
          end
          q_r   <= {q_r[15:0], ge_c};
          div_r <= div_r >> 1;
          if (step_r == 5'd0) begin
            state_r <= S_LOGINIT;
          end else begin
            step_r <= step_r - 5'd1;
          end
        end
        S_LOGINIT: begin
          q_r    <= p_c;
          k_r    <= kp_c;
          z_r    <= {15'd0, p_c} << (5'd30 - kp_c);
          frac_r <= '0;
          step_r <= 5'd23;
          state_r <= (p_c == 17'd0) ? S_EMIT : S_LOG;
        end
        S_LOG: begin
          z_r    <= zs_c[31] ? (zs_c >> 1) : zs_c;
          frac_r <= {frac_r[22:0], zs_c[31]};
          if (step_r == 5'd0) begin
            state_r <= S_LNMUL;
          end else begin
            step_r <= step_r - 5'd1;
          end
        end
        S_LNMUL: begin
          ln_r    <= lnp_c[60:32];
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r   <= acc_r + 46'(q_r * ln_r);
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!odfl_r) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_PASS;
          end else if (out_free_c) begin
            out_kind_r    <= 1'b0;
            out_value_r   <= q_r;
            out_dropped_r <= drop_r;
            out_eov_r     <= 1'b0;
            idx_r         <= idx_r + 1'b1;
            state_r       <= S_PASS;
          end
        end
        S_RES_MUL: begin
          ex_r    <= exm_c[54:24];
          state_r <= S_RES_EXP;
        end
        S_RES_EXP: begin
          state_r <= S_RES_WAIT;
        end
        S_RES_WAIT: begin
          if (exp_done) begin
            vres_r  <= exp_res[16:0];
            state_r <= S_RES_EMIT;
          end
        end
        S_RES_EMIT: begin
          if (out_free_c) begin
            out_kind_r    <= 1'b1;
            out_value_r   <= vres_r;
            out_dropped_r <= drop_r;
            out_eov_r     <= 1'b1;
            sum_r         <= '0;
            cnt_r         <= '0;
            ovf_r         <= 1'b0;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_value        = out_value_r;
  assign out_dropped      = out_dropped_r;
  assign out_end_of_voxel = out_eov_r;

  `SEV_ASSERT(a_cnt_range, cnt_r <= CNT_MAX)
  `SEV_ASSERT_IMP(a_exp_done_wait, exp_done, (state_r == S_WEXP) || (state_r == S_RES_WAIT))
  `SEV_ASSERT_NXT(a_voxel_clear, (state_r == S_RES_EMIT) && out_free_c, (cnt_r == '0) && !ovf_r)

endmodule
`default_nettype wire

FILE: dv/sev_checker.sv
// result checker for the softmax entropy vesselness block
// watches the request, result and register ports and predicts every result
// uses sev_pkg for the register indexes and the exp and log constants
`timescale 1ns / 100ps
module sev_checker
  import sev_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_sample,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_kind,
  input  logic [16:0]        out_value,
  input  logic               out_dropped,
  input  logic               out_end_of_voxel,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  localparam int CAPACITY = 32;

  typedef struct packed {
    logic        kind;
    logic [16:0] value;
    logic        dropped;
    logic        eov;
  } voxel_result_t;

  voxel_result_t expected_results[$];

  logic [23:0]        beta_q;
  logic [23:0]        tau_q;
  logic               odf_q;
  longint unsigned    weights[CAPACITY];
  longint unsigned    weight_total;
  int                 stored;
  logic               overflow;

  function automatic longint unsigned exp_q(input longint signed x, input int outbits);
    longint signed   c;
    longint signed   y;
    longint unsigned u;
    longint unsigned f;
    longint unsigned g;
    longint unsigned term;
    longint unsigned m;
    int              ip;
    int              s;
    c = longint'(LOG2E_Q30);
    y = x * c;
    u = y + (64'sd40 <<< 46);
    ip = int'(u >> 46) - 40;
    f = (u & ((64'd1 << 46) - 1)) >> 14;
    g = (f * LN2_Q32) >> 32;
    term = 64'd1 << 32;
    m = term;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * g) >> 32) / n;
      m += term;
    end
    s = ip + outbits - 32;
    if (s >= 0) return m << s;
    s = -s;
    if (s > 62) return 0;
    return (m + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic longint unsigned neg_ln_prob(input longint unsigned p);
    int              k;
    longint unsigned z;
    longint unsigned frac;
    longint unsigned nl;
    k = 0;
    frac = 0;
    while (k < 16 && (p >> (k + 1)) != 0) k++;
    z = p << (30 - k);
    for (int b = 0; b < 24; b++) begin
      z = (z * z) >> 30;
      frac <<= 1;
      if (z >= (64'd1 << 31)) begin
        z >>= 1;
        frac |= 1;
      end
    end
    nl = (longint'(16 - k) << 24) - frac;
    return (nl * LN2_Q32) >> 32;
  endfunction

  task automatic take_sample(input logic signed [15:0] s, input logic last);
    longint signed   v;
    longint signed   b;
    longint signed   x;
    longint unsigned p;
    longint unsigned acc;
    longint unsigned ne;
    longint unsigned ex;
    logic            norm;
    voxel_result_t   r;
    v = longint'(s);
    b = longint'(beta_q);
    acc = 0;
    if (stored < CAPACITY) begin
      x = -(b * v);
      if (x < -64'sd1572864) x = -64'sd1572864;
      if (x > 64'sd1048575) x = 64'sd1048575;
      weights[stored] = exp_q(x, 24) & ((64'd1 << 48) - 1);
      weight_total = (weight_total + weights[stored]) & ((64'd1 << 54) - 1);
      stored++;
    end else begin
      overflow = 1'b1;
    end
    if (!last) return;
    norm = weight_total > 16;
    for (int i = 0; i < stored; i++) begin
      p = 0;
      if (norm) p = ((weights[i] << 16) + (weight_total >> 1)) / weight_total;
      if (p > 65536) p = 65536;
      if (p >= 1) acc += p * neg_ln_prob(p);
      if (odf_q) begin
        r.kind = 1'b0;
        r.value = p[16:0];
        r.dropped = overflow;
        r.eov = 1'b0;
        expected_results.push_back(r);
      end
    end
    ne = (acc + (64'd1 << 15)) >> 16;
    if (ne > (64'd1 << 36)) ne = 64'd1 << 36;
    ex = (longint'(tau_q) * ne + (64'd1 << 23)) >> 24;
    x = (ex > 64'd1572864) ? -64'sd1572864 : -longint'(ex);
    r.kind = 1'b1;
    r.value = 17'(exp_q(x, 16));
    r.dropped = overflow;
    r.eov = 1'b1;
    expected_results.push_back(r);
    weight_total = 0;
    stored = 0;
    overflow = 1'b0;
  endtask

  always @(posedge clk) begin
    voxel_result_t e;
    if (!rst_n) begin
      beta_q <= 24'd655;
      tau_q <= 24'd65536;
      odf_q <= 1'b0;
      weight_total = 0;
      stored = 0;
      overflow = 1'b0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d value %0d", out_kind, out_value);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_kind);
            fail_count++;
          end
          if (out_value !== e.value) begin
            $error("value: expected %0d, got %0d", e.value, out_value);
            fail_count++;
          end
          if (out_dropped !== e.dropped) begin
            $error("dropped: expected %0d, got %0d", e.dropped, out_dropped);
            fail_count++;
          end
          if (out_end_of_voxel !== e.eov) begin
            $error("end_of_voxel: expected %0d, got %0d", e.eov, out_end_of_voxel);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) take_sample(in_sample, in_last);
      if (cfg_we) begin
        case (cfg_index)
          REG_BETA: beta_q <= cfg_wdata;
          REG_TAU:  tau_q <= cfg_wdata;
          REG_ODF:  odf_q <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: dv/testbench.sv
// top of the softmax entropy vesselness testbench
// drives voxel sample requests, register writes and result back-pressure
// depends on sev_pkg, sev_checker and the block itself
`timescale 1ns / 100ps
module testbench;
  import sev_pkg::*;

  localparam int LIMIT = 2000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_sample;
  logic               in_last;
  logic               out_valid;
  logic               out_ready;
  logic               out_kind;
  logic [16:0]        out_value;
  logic               out_dropped;
  logic               out_end_of_voxel;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [23:0]        cfg_wdata;
  int                 fail_count;
  int                 pending;
  int                 cycles;
  int                 accepted;
  int                 sent;
  logic               calm;
  logic               held;

  softmax_entropy_vesselness DUT (.*);

  sev_checker u_checker (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (in_valid && in_ready) accepted++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls and one long hold while requests keep coming
  initial begin
    int stall;
    out_ready = 1'b0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && accepted >= 80) begin
        held = 1'b1;
        out_ready = 1'b0;
        repeat (3000) @(negedge clk);
      end
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        stall = $urandom_range(1, 13);
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  task automatic send(input logic signed [15:0] s, input logic last);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = s;
    in_last = last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  task automatic random_voxel();
    int len;
    case ($urandom_range(0, 11))
      0: len = $urandom_range(33, 36);
      1: len = 32;
      default: len = $urandom_range(1, 12);
    endcase
    for (int i = 1; i <= len; i++) send(pick_sample(), i == len);
  endtask

  initial begin
    logic [23:0] betas[6];
    logic [23:0] taus[6];
    logic        odfs[6];
    sent = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_last = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_BETA;
    cfg_wdata = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset settings, single sample, extremes, tiny sum, near uniform
    send(16'sd0, 1'b1);
    send(16'sh8000, 1'b0);
    send(16'sh7FFF, 1'b1);
    repeat (4) send(16'sh7FFF, 1'b0);
    send(16'sh7FFF, 1'b1);
    send(16'sd1, 1'b0);
    send(-16'sd1, 1'b0);
    send(16'sd100, 1'b0);
    send(-16'sd100, 1'b1);
    settle();
    write_reg(REG_ODF, 24'd1);
    send(16'sd5, 1'b0);
    send(-16'sd300, 1'b0);
    send(16'sh8000, 1'b0);
    send(16'sd0, 1'b1);
    send(16'sh7FFF, 1'b0);
    send(16'sh7FFF, 1'b1);
    send(16'sd42, 1'b1);
    settle();

    betas = '{24'd0, 24'hFFFFFF, 24'd65536, 24'd3000, 24'd655, 24'd0};
    taus = '{24'd0, 24'hFFFFFF, 24'd32768, 24'd200000, 24'd65536, 24'd0};
    odfs = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    betas[5] = 24'($urandom);
    taus[5] = 24'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_BETA, betas[ph]);
      write_reg(REG_TAU, taus[ph]);
      write_reg(REG_ODF, {23'd0, odfs[ph]});
      if (ph == 5) calm = 1'b1;
      while (sent < 17 + 34 * (ph + 1)) random_voxel();
      settle();
    end

    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
